FILE: design/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked while out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: design/gbmc_pkg.sv
// shared types, constants and helpers of the gamepad binding mapper
package gbmc_pkg;

	localparam int LOGICAL_COUNT = 12;
	localparam int BUTTON_COUNT  = 128;
	localparam int AXIS_COUNT    = 6;

	localparam int BTN_W      = 128;
	localparam int BTN_IDX_W  = 7;
	localparam int AXIS_W     = 16;
	localparam int STEP_W     = $clog2(LOGICAL_COUNT + 1);
	localparam int OUT_STEP_W = 4;

	localparam logic [STEP_W-1:0] TRIGGER_STEP_A = STEP_W'(6);
	localparam logic [STEP_W-1:0] TRIGGER_STEP_B = STEP_W'(7);
	localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(LOGICAL_COUNT);

	localparam logic [15:0] THRESHOLD_RESET = 16'd4096;

	localparam logic [31:0] HAT_CENTER = 32'hFFFF_FFFF;
	localparam logic [31:0] HAT_RECIP  = 32'd3909374676; // floor(2^47 / 36000)
	localparam int          HAT_SHIFT  = 47;
	localparam logic [16:0] HAT_TURN   = 17'd36000;
	localparam logic [16:0] HAT_UL     = 17'd31500;
	localparam logic [16:0] HAT_UR     = 17'd4500;
	localparam logic [16:0] HAT_DR     = 17'd13500;
	localparam logic [16:0] HAT_DL     = 17'd22500;

	typedef enum logic [1:0] {
		KIND_BUTTON,
		KIND_AXIS_POS,
		KIND_AXIS_NEG
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BTN_IDX_W-1:0] idx;
		logic [AXIS_W-1:0]  base;
	} binding_t;

	typedef logic [AXIS_COUNT-1:0][AXIS_W-1:0] axis_arr_t;
	typedef binding_t [LOGICAL_COUNT-1:0] table_t;

	// one classified snapshot on its way from front to back
	typedef struct packed {
		logic                 op;
		logic [BTN_W-1:0]     buttons;
		axis_arr_t            axes;
		logic                 hat_live;
		logic [3:0]           dpad;
		logic                 any_btn;
		logic [BTN_IDX_W-1:0] first_btn;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic binding_t default_binding(input int i);
		binding_t b;
		b.kind = KIND_BUTTON;
		b.idx  = BTN_IDX_W'(i);
		b.base = '0;
		return b;
	endfunction

endpackage

FILE: design/gbmc_front.sv
// front end: takes snapshots, finds the first pressed button and decodes the hat
module gbmc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic                    operation,
	input  logic [63:0]             buttons_low,
	input  logic [63:0]             buttons_high,
	input  gbmc_pkg::axis_arr_t     axes,
	input  logic [31:0]             pov_angle,
	input  gbmc_pkg::qstat_t        q_stat,
	output logic                    q_wr,
	output gbmc_pkg::item_t         q_item
);
	import gbmc_pkg::*;

	logic                 v_s1, v_s2;
	logic                 en1, en2;
	logic                 op_s1;
	logic [BTN_W-1:0]     btn_s1;
	axis_arr_t            axes_s1;
	logic [31:0]          pov_s1;
	logic [63:0]          prod_s1;
	logic                 any_s1;
	logic [BTN_IDX_W-1:0] first_s1;
	item_t                item_s2;

	logic [BTN_W-1:0]     btn_in;
	logic [BTN_IDX_W-1:0] first_c;
	logic [16:0]          quot;
	logic [32:0]          qmul;
	logic [31:0]          rem_raw;
	logic [16:0]          rem;
	logic [16:0]          ang;
	logic [3:0]           dpad_c;

	assign en2  = !v_s2 || !q_stat.full;
	assign en1  = !v_s1 || en2;
	assign full = !en1;
	assign q_wr = v_s2 && !q_stat.full;
	assign q_item = item_s2;

	// buttons past the count never show up downstream
	always_comb begin
		btn_in = {buttons_high, buttons_low};
		for (int b = 0; b < BTN_W; b++) begin
			if (b >= BUTTON_COUNT) begin
				btn_in[b] = 1'b0;
			end
		end
	end

	// lowest pressed button wins
	always_comb begin
		first_c = '0;
		for (int b = BTN_W - 1; b >= 0; b--) begin
			if (btn_in[b]) begin
				first_c = BTN_IDX_W'(b);
			end
		end
	end

	// quotient from the reciprocal is exact or one short, so one correction
	always_comb begin
		quot    = prod_s1[HAT_SHIFT +: 17];
		qmul    = quot * HAT_TURN[15:0];
		rem_raw = pov_s1 - qmul[31:0];
		rem     = rem_raw[16:0];
		ang     = (rem >= HAT_TURN) ? rem - HAT_TURN : rem;
		dpad_c  = '0;
		if (pov_s1 != HAT_CENTER) begin
			dpad_c[0] = (ang >= HAT_UL) || (ang <= HAT_UR);
			dpad_c[1] = (ang >= HAT_UR) && (ang <= HAT_DR);
			dpad_c[2] = (ang >= HAT_DR) && (ang <= HAT_DL);
			dpad_c[3] = (ang >= HAT_DL) && (ang <= HAT_UL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= push;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && push) begin
			op_s1    <= operation;
			btn_s1   <= btn_in;
			axes_s1  <= axes;
			pov_s1   <= pov_angle;
			prod_s1  <= pov_angle * HAT_RECIP;
			any_s1   <= |btn_in;
			first_s1 <= first_c;
		end
		if (en2 && v_s1) begin
			item_s2.op        <= op_s1;
			item_s2.buttons   <= btn_s1;
			item_s2.axes      <= axes_s1;
			item_s2.hat_live  <= (pov_s1 != HAT_CENTER);
			item_s2.dpad      <= dpad_c;
			item_s2.any_btn   <= any_s1;
			item_s2.first_btn <= first_s1;
		end
	end

endmodule

FILE: design/gbmc_queue.sv
// four-entry queue of classified snapshots between front and back
module gbmc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  gbmc_pkg::item_t   wr_item,
	input  logic              rd,
	output gbmc_pkg::item_t   rd_item,
	output gbmc_pkg::qstat_t  stat
);
	import gbmc_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	item_t              mem [DEPTH];
	logic [PTR_W-1:0]   wp_q, rp_q;
	logic [PTR_W:0]     cnt_q;

	assign stat.full  = (cnt_q == (PTR_W + 1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_item    = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= wr_item;
		end
	end

endmodule

FILE: design/gbmc_back.sv
// back end: calibration state, binding tables and the result register
module gbmc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbmc_pkg::qstat_t             q_stat,
	input  gbmc_pkg::item_t              it,
	output logic                         q_rd,
	input  logic [15:0]                  threshold,
	output logic                         empty,
	input  logic                         pop,
	output logic [11:0]                  logical_pressed,
	output logic [3:0]                   dpad_mask,
	output logic                         any_input,
	output logic                         calibrating,
	output logic [3:0]                   calibration_step,
	output logic                         awaiting_release,
	output logic                         mapping_done
);
	import gbmc_pkg::*;

	table_t                         bind_q, work_q, bind_n, work_n;
	axis_arr_t                      base_q, base_n;
	logic                           cal_q, cal_n;
	logic                           bt_q, bt_n;
	logic                           rw_q, rw_n;
	logic [STEP_W-1:0]              step_q, step_n;
	logic                           out_v_q;

	logic                           done_c;
	logic [LOGICAL_COUNT-1:0]       logic_c;
	logic [AXIS_COUNT-1:0]          rel_ok;
	logic signed [17:0]             d    [AXIS_COUNT];
	logic [16:0]                    mag  [AXIS_COUNT];
	logic signed [17:0]             thr_s;
	logic [16:0]                    best;
	logic                           sel_v;
	logic                           found;
	binding_t                       bd;
	binding_t                       ent;
	logic signed [17:0]             bd_d;
	logic [AXIS_W-1:0]              ax_v;
	logic                           ax_ok;

	assign q_rd  = !q_stat.empty && (!out_v_q || pop);
	assign empty = !out_v_q;
	assign thr_s = $signed({2'b00, threshold});

	always_comb begin
		for (int a = 0; a < AXIS_COUNT; a++) begin
			d[a]      = $signed({2'b00, it.axes[a]}) - $signed({2'b00, base_q[a]});
			mag[a]    = d[a][17] ? 17'(-d[a]) : d[a][16:0];
			rel_ok[a] = (mag[a] <= {1'b0, threshold});
		end
	end

	// calibration step for one beat
	always_comb begin
		bind_n = bind_q;
		work_n = work_q;
		base_n = base_q;
		cal_n  = cal_q;
		bt_n   = bt_q;
		rw_n   = rw_q;
		step_n = step_q;
		done_c = 1'b0;
		found  = 1'b0;
		bd     = default_binding(0);
		best   = {1'b0, threshold};
		sel_v  = 1'b0;
		if (it.op) begin
			cal_n  = 1'b1;
			bt_n   = 1'b0;
			rw_n   = 1'b1;
			step_n = '0;
			base_n = '0;
			for (int i = 0; i < LOGICAL_COUNT; i++) begin
				work_n[i] = default_binding(i);
			end
		end else if (cal_q) begin
			if (!bt_q) begin
				if (!it.any_btn) begin
					base_n = it.axes;
					bt_n   = 1'b1;
					rw_n   = 1'b0;
				end
			end else if (rw_q) begin
				if (!it.any_btn && (&rel_ok)) begin
					rw_n = 1'b0;
				end
			end else begin
				if (it.any_btn) begin
					found    = 1'b1;
					bd.kind  = KIND_BUTTON;
					bd.idx   = it.first_btn;
					bd.base  = '0;
				end else if (step_q == TRIGGER_STEP_A || step_q == TRIGGER_STEP_B) begin
					// largest deviation past the threshold, lowest axis on ties
					for (int a = 0; a < AXIS_COUNT; a++) begin
						if (mag[a] > best) begin
							best    = mag[a];
							sel_v   = 1'b1;
							bd.kind = d[a][17] ? KIND_AXIS_NEG : KIND_AXIS_POS;
							bd.idx  = BTN_IDX_W'(a);
							bd.base = base_q[a];
						end
					end
					found = sel_v;
				end
				if (found) begin
					for (int i = 0; i < LOGICAL_COUNT; i++) begin
						if (step_q == STEP_W'(i)) begin
							work_n[i] = bd;
						end
					end
					step_n = step_q + 1'b1;
					rw_n   = 1'b1;
					if (step_n == STEP_LAST) begin
						bind_n = work_n;
						cal_n  = 1'b0;
						done_c = 1'b1;
					end
				end
			end
		end
	end

	// mapping against the table as it stands after this beat
	always_comb begin
		logic_c = '0;
		for (int i = 0; i < LOGICAL_COUNT; i++) begin
			ent   = bind_n[i];
			ax_v  = '0;
			ax_ok = 1'b0;
			for (int a = 0; a < AXIS_COUNT; a++) begin
				if (ent.idx == BTN_IDX_W'(a)) begin
					ax_v  = it.axes[a];
					ax_ok = 1'b1;
				end
			end
			bd_d = $signed({2'b00, ax_v}) - $signed({2'b00, ent.base});
			unique case (ent.kind)
				KIND_BUTTON:   logic_c[i] = it.buttons[ent.idx];
				KIND_AXIS_POS: logic_c[i] = ax_ok && (bd_d > thr_s);
				KIND_AXIS_NEG: logic_c[i] = ax_ok && (bd_d < -thr_s);
				default:       logic_c[i] = 1'b0;
			endcase
		end
		if (it.op) begin
			logic_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOGICAL_COUNT; i++) begin
				bind_q[i] <= default_binding(i);
				work_q[i] <= default_binding(i);
			end
			base_q  <= '0;
			cal_q   <= 1'b0;
			bt_q    <= 1'b0;
			rw_q    <= 1'b1;
			step_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_rd) begin
				bind_q  <= bind_n;
				work_q  <= work_n;
				base_q  <= base_n;
				cal_q   <= cal_n;
				bt_q    <= bt_n;
				rw_q    <= rw_n;
				step_q  <= step_n;
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			logical_pressed  <= 12'(logic_c);
			dpad_mask        <= it.op ? 4'b0 : it.dpad;
			any_input        <= (|logic_c) || (!it.op && it.hat_live);
			calibrating      <= cal_n;
			calibration_step <= OUT_STEP_W'(step_n);
			awaiting_release <= cal_n && (!bt_n || rw_n);
			mapping_done     <= done_c;
		end
	end

endmodule

FILE: design/gamepad_binding_mapper_calibrator_top.sv
// top level of the gamepad binding mapper with guided calibration
//
// Input channel: drive a snapshot (operation = 0) or a start-calibration
// command (operation = 1) with push; a beat is taken when push is high and
// full is low. Result channel: while empty is low the oldest result sits on
// the result ports and pop takes it. One result comes out per input beat,
// in order.
// A taken beat passes the two front stages for the hat decode, the queue
// write and the result register, in that order. Throughput: one beat per
// cycle when nothing stalls, set by the combinational calibration and
// mapping step in the back end.
// When pop stays low the result register holds, the four-entry queue fills
// and then the front stages; full rises once all are occupied.
// Threshold: write with cfg_valid; cfg_ready is always high. Write only
// while no beat is in flight.
// Reset (arst_n low) empties all stages, restores the default bindings
// (slot i on button i), stops calibration and sets the threshold to 4096.
module gamepad_binding_mapper_calibrator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [63:0] buttons_low,
	input  logic [63:0] buttons_high,
	input  logic [15:0] axis_x,
	input  logic [15:0] axis_y,
	input  logic [15:0] axis_z,
	input  logic [15:0] axis_rx,
	input  logic [15:0] axis_ry,
	input  logic [15:0] axis_rz,
	input  logic [31:0] pov_angle,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] logical_pressed,
	output logic [3:0]  dpad_mask,
	output logic        any_input,
	output logic        calibrating,
	output logic [3:0]  calibration_step,
	output logic        awaiting_release,
	output logic        mapping_done
);
	import gbmc_pkg::*;

	logic [5:0][15:0] axes_all;
	axis_arr_t        axes;
	logic [15:0]      threshold_q;
	qstat_t           q_stat;
	logic             q_wr, q_rd;
	item_t            q_in, q_out;

	assign axes_all  = {axis_rz, axis_ry, axis_rx, axis_z, axis_y, axis_x};
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int a = 0; a < AXIS_COUNT; a++) begin
			axes[a] = axes_all[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	gbmc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.buttons_low  (buttons_low),
		.buttons_high (buttons_high),
		.axes         (axes),
		.pov_angle    (pov_angle),
		.q_stat       (q_stat),
		.q_wr         (q_wr),
		.q_item       (q_in)
	);

	gbmc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_item (q_in),
		.rd      (q_rd),
		.rd_item (q_out),
		.stat    (q_stat)
	);

	gbmc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_stat           (q_stat),
		.it               (q_out),
		.q_rd             (q_rd),
		.threshold        (threshold_q),
		.empty            (empty),
		.pop              (pop),
		.logical_pressed  (logical_pressed),
		.dpad_mask        (dpad_mask),
		.any_input        (any_input),
		.calibrating      (calibrating),
		.calibration_step (calibration_step),
		.awaiting_release (awaiting_release),
		.mapping_done     (mapping_done)
	);

endmodule

FILE: design/gbmc_checker.sv
// port-level checks of the mapper, bound to the top level
`include "assert_macros.svh"

module gbmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [11:0] logical_pressed,
	input logic [3:0]  dpad_mask,
	input logic        any_input,
	input logic        calibrating,
	input logic [3:0]  calibration_step,
	input logic        awaiting_release,
	input logic        mapping_done
);
	import gbmc_pkg::*;

	`ASSERT_IMPLIES(a_done_ends_cal, clk, arst_n, !empty && mapping_done, !calibrating && calibration_step == 4'(LOGICAL_COUNT))
	`ASSERT_IMPLIES(a_wait_needs_cal, clk, arst_n, !empty && awaiting_release, calibrating)
	`ASSERT_IMPLIES(a_activity_flag, clk, arst_n, !empty && (dpad_mask != 4'b0 || logical_pressed != 12'b0), any_input)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, !empty && !pop, !empty && $stable(logical_pressed) && $stable(calibration_step))

endmodule

bind gamepad_binding_mapper_calibrator_top gbmc_checker u_gbmc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.empty            (empty),
	.pop              (pop),
	.logical_pressed  (logical_pressed),
	.dpad_mask        (dpad_mask),
	.any_input        (any_input),
	.calibrating      (calibrating),
	.calibration_step (calibration_step),
	.awaiting_release (awaiting_release),
	.mapping_done     (mapping_done)
);

FILE: dv/gamepad_binding_mapper_calibrator_top_tb.sv
// testbench for the gamepad binding mapper: directed, calibration, backpressure and random snapshot tests
module gamepad_binding_mapper_calibrator_top_tb;
	import gbmc_pkg::*;

	typedef struct {
		logic        op;
		logic [63:0] btn_lo;
		logic [63:0] btn_hi;
		logic [15:0] ax [6];
		logic [31:0] pov;
	} snap_t;

	typedef struct packed {
		logic [11:0] pressed;
		logic [3:0]  dpad;
		logic        any_in;
		logic        cal;
		logic [3:0]  step;
		logic        await_rel;
		logic        done;
	} pad_result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	logic        operation = 0;
	logic [63:0] buttons_low = '0;
	logic [63:0] buttons_high = '0;
	logic [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic [15:0] axis_rx = '0, axis_ry = '0, axis_rz = '0;
	logic [31:0] pov_angle = '0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        empty;
	logic        pop = 0;
	logic [11:0] logical_pressed;
	logic [3:0]  dpad_mask;
	logic        any_input;
	logic        calibrating;
	logic [3:0]  calibration_step;
	logic        awaiting_release;
	logic        mapping_done;

	gamepad_binding_mapper_calibrator_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	binding_t    live_map [LOGICAL_COUNT];
	binding_t    learn_map [LOGICAL_COUNT];
	logic [15:0] base_pos [6];
	logic        cal_on, base_ok, rel_wait;
	logic [4:0]  learn_idx;
	logic [15:0] thresh;

	pad_result_t expected_results [$];
	int errors = 0, results_seen = 0, commits_seen = 0, cycles = 0;
	int hold_off = 0;
	bit stall_mode = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		errors++;
		$display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, exp);
	endtask

	function automatic logic btn_down(input snap_t s, input int b);
		return b < 64 ? s.btn_lo[b] : s.btn_hi[b-64];
	endfunction

	function automatic int deviation(input snap_t s, input int a, input logic [15:0] b);
		return int'(s.ax[a]) - int'(b);
	endfunction

	function automatic logic binding_on(input snap_t s, input binding_t bd);
		int d;
		if (bd.kind == KIND_BUTTON) return btn_down(s, bd.idx);
		if (bd.idx >= AXIS_COUNT) return 0;
		d = deviation(s, bd.idx, bd.base);
		if (bd.kind == KIND_AXIS_POS) return d > int'(thresh);
		if (bd.kind == KIND_AXIS_NEG) return d < -int'(thresh);
		return 0;
	endfunction

	function automatic logic [3:0] hat_dirs(input logic [31:0] pov);
		logic [3:0] m = '0;
		logic [31:0] p;
		if (pov == HAT_CENTER) return '0;
		p = pov % 36000;
		if (p >= 31500 || p <= 4500) m[0] = 1;
		if (p >= 4500 && p <= 13500) m[1] = 1;
		if (p >= 13500 && p <= 22500) m[2] = 1;
		if (p >= 22500 && p <= 31500) m[3] = 1;
		return m;
	endfunction

	function automatic void reset_maps(input bit both);
		for (int i = 0; i < LOGICAL_COUNT; i++) begin
			learn_map[i] = '{KIND_BUTTON, 7'(i), 16'd0};
			if (both) live_map[i] = learn_map[i];
		end
	endfunction

	// calibration step; returns 1 when the learned map was committed
	function automatic logic learn(input snap_t s);
		logic any_b, found, quiet;
		binding_t bd;
		int d, m, best, best_d, sel;
		if (!cal_on) return 0;
		any_b = |{s.btn_lo, s.btn_hi};
		if (!base_ok) begin
			if (any_b) return 0;
			for (int a = 0; a < 6; a++) base_pos[a] = s.ax[a];
			base_ok = 1;
			rel_wait = 0;
			return 0;
		end
		if (rel_wait) begin
			quiet = !any_b;
			for (int a = 0; a < 6; a++) begin
				d = deviation(s, a, base_pos[a]);
				if (d > int'(thresh) || d < -int'(thresh)) quiet = 0;
			end
			if (quiet) rel_wait = 0;
			return 0;
		end
		found = 0;
		for (int b = 0; b < 128 && !found; b++)
			if (btn_down(s, b)) begin
				bd = '{KIND_BUTTON, 7'(b), 16'd0};
				found = 1;
			end
		if (!found && (learn_idx == 6 || learn_idx == 7)) begin
			best = int'(thresh);
			best_d = 0;
			sel = 6;
			for (int a = 0; a < 6; a++) begin
				d = deviation(s, a, base_pos[a]);
				m = d < 0 ? -d : d;
				if (m > best) begin
					best = m;
					best_d = d;
					sel = a;
				end
			end
			if (sel < 6) begin
				bd.kind = best_d > 0 ? KIND_AXIS_POS : KIND_AXIS_NEG;
				bd.idx = 7'(sel);
				bd.base = base_pos[sel];
				found = 1;
			end
		end
		if (!found) return 0;
		learn_map[learn_idx] = bd;
		learn_idx++;
		rel_wait = 1;
		if (learn_idx < LOGICAL_COUNT) return 0;
		live_map = learn_map;
		cal_on = 0;
		return 1;
	endfunction

	function automatic pad_result_t predict_pad(input snap_t s);
		pad_result_t r = '0;
		if (s.op) begin
			cal_on = 1;
			base_ok = 0;
			rel_wait = 1;
			learn_idx = 0;
			for (int a = 0; a < 6; a++) base_pos[a] = '0;
			reset_maps(0);
		end else begin
			r.done = learn(s);
			for (int i = 0; i < LOGICAL_COUNT; i++) r.pressed[i] = binding_on(s, live_map[i]);
			r.dpad = hat_dirs(s.pov);
			r.any_in = (r.pressed != 0) || (s.pov != HAT_CENTER);
		end
		r.cal = cal_on;
		r.step = learn_idx[3:0];
		r.await_rel = cal_on && (!base_ok || rel_wait);
		return r;
	endfunction

	// sender: one beat, with a random gap afterwards when bursting ends
	task automatic send_snap(input snap_t s);
		pad_result_t r;
		push <= 1;
		operation <= s.op;
		buttons_low <= s.btn_lo;
		buttons_high <= s.btn_hi;
		{axis_x, axis_y, axis_z} <= {s.ax[0], s.ax[1], s.ax[2]};
		{axis_rx, axis_ry, axis_rz} <= {s.ax[3], s.ax[4], s.ax[5]};
		pov_angle <= s.pov;
		do @(posedge clk); while (full);
		r = predict_pad(s);
		expected_results = {expected_results, r};
		@(negedge clk);
		if ($urandom_range(0, 5) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic go_idle();
		push <= 0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] v);
		go_idle();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		thresh = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic snap_t quiet_snap();
		snap_t s;
		s.op = 0;
		s.btn_lo = '0;
		s.btn_hi = '0;
		for (int a = 0; a < 6; a++) s.ax[a] = 16'h8000;
		s.pov = HAT_CENTER;
		return s;
	endfunction

	function automatic snap_t rand_snap();
		snap_t s;
		s.op = ($urandom_range(0, 40) == 0);
		s.btn_lo = {$urandom, $urandom};
		s.btn_hi = {$urandom, $urandom};
		if ($urandom_range(0, 1)) s.btn_lo = '0;
		if ($urandom_range(0, 1)) s.btn_hi = '0;
		for (int a = 0; a < 6; a++) s.ax[a] = 16'($urandom);
		case ($urandom_range(0, 3))
			0: s.pov = HAT_CENTER;
			1: s.pov = $urandom_range(0, 36000);
			default: s.pov = $urandom;
		endcase
		return s;
	endfunction

	// a full calibration walk with random content and some noise
	task automatic calibrate_walk();
		snap_t s;
		int b;
		s = quiet_snap();
		s.op = 1;
		send_snap(s);
		s = quiet_snap();
		for (int a = 0; a < 6; a++) s.ax[a] = 16'($urandom);
		send_snap(s);
		for (int st = 0; st < LOGICAL_COUNT; st++) begin
			snap_t p = s;
			p.pov = $urandom_range(0, 3) == 0 ? HAT_CENTER : $urandom;
			if ((st == 6 || st == 7) && $urandom_range(0, 1)) begin
				int a = $urandom_range(0, 5);
				p.ax[a] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end else begin
				b = $urandom_range(0, 127);
				if (b < 64) p.btn_lo[b] = 1; else p.btn_hi[b-64] = 1;
				if ($urandom_range(0, 3) == 0) p.btn_hi |= {$urandom, $urandom};
			end
			send_snap(p);
			if ($urandom_range(0, 4) == 0) send_snap(rand_snap());
			send_snap(s);
		end
	endtask

	task automatic test_directed();
		snap_t s;
		logic [31:0] povs [8] = '{0, 4500, 13500, 22500, 31500, 35999, 36000, 32'hFFFF_FFFE};
		s = quiet_snap();
		send_snap(s);
		s.btn_lo = '1;
		s.btn_hi = '1;
		send_snap(s);
		s = quiet_snap();
		s.btn_hi[63] = 1;
		s.btn_lo[0] = 1;
		send_snap(s);
		foreach (povs[i]) begin
			s = quiet_snap();
			s.pov = povs[i];
			send_snap(s);
		end
		s = quiet_snap();
		for (int a = 0; a < 6; a++) s.ax[a] = 16'hFFFF;
		send_snap(s);
		s.op = 1;
		s.btn_lo = '1;
		s.pov = 0;
		send_snap(s);
		s = quiet_snap();
		s.btn_lo[3] = 1;
		send_snap(s);
	endtask

	task automatic test_calibration();
		write_threshold(16'd4096);
		calibrate_walk();
		write_threshold(16'd0);
		calibrate_walk();
		write_threshold(16'hFFFF);
		calibrate_walk();
		for (int i = 0; i < 20; i++) send_snap(rand_snap());
	endtask

	task automatic test_backpressure();
		go_idle();
		hold_off = 200;
		for (int i = 0; i < 30; i++) send_snap(rand_snap());
	endtask

	task automatic test_random();
		for (int k = 0; k < 8; k++) begin
			write_threshold(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9000)));
			if (k % 2) calibrate_walk();
			for (int i = 0; i < 80; i++) send_snap(rand_snap());
		end
	endtask

	// receiver: pops on a stall pattern of its own
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			pop <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode <= !stall_mode;
			pop <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		pad_result_t e;
		cycles++;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				report("unexpected beat", 0, 0);
			end else begin
				e = expected_results.pop_front();
				if (logical_pressed !== e.pressed)
					report("logical_pressed", 32'(logical_pressed), 32'(e.pressed));
				if (dpad_mask !== e.dpad) report("dpad_mask", 32'(dpad_mask), 32'(e.dpad));
				if (any_input !== e.any_in) report("any_input", 32'(any_input), 32'(e.any_in));
				if (calibrating !== e.cal) report("calibrating", 32'(calibrating), 32'(e.cal));
				if (calibration_step !== e.step)
					report("calibration_step", 32'(calibration_step), 32'(e.step));
				if (awaiting_release !== e.await_rel)
					report("awaiting_release", 32'(awaiting_release), 32'(e.await_rel));
				if (mapping_done !== e.done)
					report("mapping_done", 32'(mapping_done), 32'(e.done));
				if (e.done) commits_seen++;
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (cycles > 200000) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		reset_maps(1);
		for (int a = 0; a < 6; a++) base_pos[a] = '0;
		cal_on = 0;
		base_ok = 0;
		rel_wait = 1;
		learn_idx = 0;
		thresh = THRESHOLD_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_calibration();
		test_backpressure();
		test_random();
		go_idle();
		$display("checked %0d results, %0d table commits, threshold extremes and a long stall",
			results_seen, commits_seen);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+design
design/gbmc_pkg.sv
design/gbmc_front.sv
design/gbmc_queue.sv
design/gbmc_back.sv
design/gamepad_binding_mapper_calibrator_top.sv
design/gbmc_checker.sv
dv/gamepad_binding_mapper_calibrator_top_tb.sv
